[design/urfc_pkg.sv]
// ----------------------------------------------------------------------------
// urfc_pkg
// shared types and constants of the uart receive frame capture unit
// ----------------------------------------------------------------------------
`default_nettype none

package urfc_pkg;

    localparam logic [15:0] BIT_PERIOD_RST = 16'd800;
    localparam logic [15:0] GAP_TICKS_RST  = 16'd2000;
    localparam logic [3:0]  FIRST_BIT_STEP = 4'd1;
    localparam logic [3:0]  LAST_BIT_STEP  = 4'd8;
    localparam logic [3:0]  LAST_STEP      = 4'd10;
    localparam logic [15:0] GAP_MAX        = 16'hFFFF;

    localparam logic [0:0] CFG_BIT_PERIOD = 1'b0;
    localparam logic [0:0] CFG_GAP_TICKS  = 1'b1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_BYTE = 3'b010,
        PH_GAP  = 3'b100
    } t_phase;

    typedef struct packed {
        logic       command;
        logic       rx_line;
        logic [4:0] read_index;
    } t_rx_in;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] rx_byte;
        logic [5:0] byte_count;
        logic       receiving;
        logic       frame_end;
        logic       overflow;
        logic [7:0] read_data;
    } t_rx_out;

    typedef struct packed {
        logic       fire;
        logic       clear;
        logic       push;
        logic [7:0] push_data;
        logic [4:0] rd_idx;
    } t_buf_req;

endpackage

`default_nettype wire

[design/urfc_buffer.sv]
// ----------------------------------------------------------------------------
// urfc_buffer
// byte buffer memory with fill count, overflow flag and registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module urfc_buffer
    import urfc_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_buf_req                     i_req,
    output logic                              o_full,
    output logic [$clog2(DEPTH + 1) - 1:0]    o_count,
    output logic                              o_overflow,
    output logic [7:0]                        o_rd_data
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W  = (CNT_W > 5) ? CNT_W : 5;

    logic [7:0]        r_mem [DEPTH];
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_overflow;
    logic              n_overflow;
    logic [7:0]        r_rd_data;
    logic              r_rd_zero;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CMP_W-1:0]  rd_idx_ext;
    logic [ADDR_W-1:0] rd_addr;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign wr_en      = i_req.fire && !i_req.clear && i_req.push && !o_full;
    assign wr_addr    = r_count[ADDR_W-1:0];
    assign rd_idx_ext = CMP_W'(i_req.rd_idx);
    assign rd_addr    = rd_idx_ext[ADDR_W-1:0];

    always_comb begin
        n_count    = r_count;
        n_overflow = r_overflow;
        if (i_req.clear) begin
            n_count    = '0;
            n_overflow = 1'b0;
        end else if (i_req.push) begin
            if (o_full) begin
                n_overflow = 1'b1;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_req.fire) begin
            r_count    <= n_count;
            r_overflow <= n_overflow;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_req.push_data;
        end
    end

    // read port, same-entry write forwarded
    always_ff @(posedge i_clk) begin
        if (i_req.fire) begin
            if (wr_en && (wr_addr == rd_addr)) begin
                r_rd_data <= i_req.push_data;
            end else begin
                r_rd_data <= r_mem[rd_addr];
            end
            r_rd_zero <= !(rd_idx_ext < CMP_W'(n_count));
        end
    end

    assign o_count    = r_count;
    assign o_overflow = r_overflow;
    assign o_rd_data  = r_rd_zero ? 8'd0 : r_rd_data;

endmodule

`default_nettype wire

[design/uart_rx_frame_capture_unit.sv]
// ----------------------------------------------------------------------------
// uart_rx_frame_capture_unit
// 8n1 uart receiver with idle-gap framing and a byte buffer
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------
//  in       | input     | i_in_valid / o_in_ready   | i_in
//  out      | output    | o_out_valid / i_out_ready | o_out
//  cfg      | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
//  one tick per cycle unless the output stalls; each transfer yields its result in the next cycle
//  the buffer memory is read and written in the transfer cycle, the read
//  data registered and forwarded when the same entry is written
//  synchronous active-low reset; buffer contents not cleared
//  a stalled output holds the input off until the result is taken
// ----------------------------------------------------------------------------
`default_nettype none

module uart_rx_frame_capture_unit
    import urfc_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_rx_in      i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_rx_out          o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    logic [15:0] r_bit_period;
    logic [15:0] r_gap_ticks;
    t_phase      r_phase,   n_phase;
    logic [15:0] r_tick,    n_tick;
    logic [3:0]  r_bit,     n_bit;
    logic [7:0]  r_shift,   n_shift;
    logic [15:0] r_gap,     n_gap;
    logic [7:0]  r_last,    n_last;
    logic        r_byte_valid;
    logic        r_frame_end, n_frame_end;
    logic        r_out_valid;
    logic        push;
    logic        in_fire;
    logic [16:0] tick_inc;
    logic [16:0] wait_len;
    logic [15:0] gap_inc;

    t_buf_req         buf_req;
    logic             buf_full;
    logic [CNT_W-1:0] buf_count;
    logic             buf_overflow;
    logic [7:0]       buf_rd_data;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RST;
            r_gap_ticks  <= GAP_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BIT_PERIOD: r_bit_period <= i_cfg_data;
                CFG_GAP_TICKS:  r_gap_ticks  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign tick_inc = {1'b0, r_tick} + 17'd1;
    assign wait_len = ((r_bit == FIRST_BIT_STEP) || (r_bit == LAST_STEP))
                      ? {2'b00, r_bit_period[15:1]} : {1'b0, r_bit_period};
    assign gap_inc  = (r_gap != GAP_MAX) ? r_gap + 16'd1 : r_gap;

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_bit       = r_bit;
        n_shift     = r_shift;
        n_gap       = r_gap;
        n_last      = r_last;
        n_frame_end = 1'b0;
        push        = 1'b0;
        if (i_in.command == CMD_SAMPLE) begin
            case (r_phase)
                PH_BYTE: begin
                    if (tick_inc >= wait_len) begin
                        n_tick = '0;
                        if ((r_bit >= FIRST_BIT_STEP) && (r_bit <= LAST_BIT_STEP)) begin
                            n_shift = {i_in.rx_line, r_shift[7:1]};
                        end
                        if (r_bit >= LAST_STEP) begin
                            n_last  = r_shift;
                            push    = 1'b1;
                            n_phase = PH_GAP;
                            n_gap   = '0;
                            n_bit   = '0;
                        end else begin
                            n_bit = r_bit + 4'd1;
                        end
                    end else begin
                        n_tick = tick_inc[15:0];
                    end
                end
                PH_GAP: begin
                    if (!i_in.rx_line) begin
                        n_phase = PH_BYTE;
                        n_tick  = '0;
                        n_bit   = '0;
                        n_shift = '0;
                    end else if (gap_inc >= r_gap_ticks) begin
                        n_frame_end = 1'b1;
                        n_phase     = PH_IDLE;
                        n_gap       = '0;
                    end else begin
                        n_gap = gap_inc;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (!i_in.rx_line) begin
                        n_phase = PH_BYTE;
                        n_tick  = '0;
                        n_bit   = '0;
                        n_shift = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick       <= '0;
            r_bit        <= '0;
            r_shift      <= '0;
            r_gap        <= '0;
            r_last       <= '0;
            r_byte_valid <= 1'b0;
            r_frame_end  <= 1'b0;
        end else if (in_fire) begin
            r_phase      <= n_phase;
            r_tick       <= n_tick;
            r_bit        <= n_bit;
            r_shift      <= n_shift;
            r_gap        <= n_gap;
            r_last       <= n_last;
            r_byte_valid <= push && !buf_full;
            r_frame_end  <= n_frame_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign buf_req.fire      = in_fire;
    assign buf_req.clear     = (i_in.command == CMD_CLEAR);
    assign buf_req.push      = push;
    assign buf_req.push_data = r_shift;
    assign buf_req.rd_idx    = i_in.read_index;

    urfc_buffer #(
        .DEPTH (BUFFER_DEPTH)
    ) u_buffer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (buf_req),
        .o_full     (buf_full),
        .o_count    (buf_count),
        .o_overflow (buf_overflow),
        .o_rd_data  (buf_rd_data)
    );

    assign o_out_valid      = r_out_valid;
    assign o_out.byte_valid = r_byte_valid;
    assign o_out.rx_byte    = r_last;
    assign o_out.byte_count = 6'(buf_count);
    assign o_out.receiving  = (r_phase != PH_IDLE);
    assign o_out.frame_end  = r_frame_end;
    assign o_out.overflow   = buf_overflow;
    assign o_out.read_data  = buf_rd_data;

endmodule

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the uart receive frame capture unit.
// Serial line ticks go in one per input transfer, and a behavioral model of
// the receiver predicts each tick's status word. Directed tests cover reset,
// extreme byte values, zero-length waits, buffer overflow and clear, and the
// widest register values. A random run follows, mostly well-formed
// frames with random data and gaps, mixed with noise and cut-off frames.
// Both handshake sides idle at random, and one test holds the output off.
// ----------------------------------------------------------------------------
module tb_top;
    import urfc_pkg::*;

    localparam int DEPTH       = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int FULL_FRAME  = 32'h7fff_ffff;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_rx_in      in_item;
    logic        out_valid;
    logic        out_ready;
    t_rx_out     out_item;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    // receiver model state
    t_phase      rx_phase;
    logic [16:0] tick_cnt;
    logic [3:0]  step_idx;
    logic [7:0]  shift_reg;
    logic [15:0] gap_cnt;
    logic [7:0]  byte_mem [DEPTH];
    logic [5:0]  held_count;
    logic        ovf_flag;
    logic [7:0]  last_rx;
    logic [15:0] period_reg;
    logic [15:0] gap_reg;

    t_rx_out     rx_out_queue [$];
    t_rx_out     want_out;

    logic        idling;
    logic        hold_req;
    int          err_count;
    int          cycle_count;
    int          n_ticks;
    int          n_clears;
    int          n_bytes;
    int          n_frames;
    int          n_ovf;

    uart_rx_frame_capture_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic void start_byte();
        rx_phase  = PH_BYTE;
        tick_cnt  = '0;
        step_idx  = '0;
        shift_reg = '0;
    endfunction

    function automatic t_rx_out rx_tick_predict(t_rx_in x);
        t_rx_out     r;
        logic [16:0] wait_len;
        logic        stored;
        logic        ended;
        stored = 1'b0;
        ended  = 1'b0;
        if (x.command == CMD_CLEAR) begin
            foreach (byte_mem[i]) byte_mem[i] = '0;
            held_count = '0;
            ovf_flag   = 1'b0;
        end else if (rx_phase == PH_BYTE) begin
            tick_cnt = tick_cnt + 17'd1;
            if (step_idx == FIRST_BIT_STEP || step_idx == LAST_STEP)
                wait_len = 17'(period_reg >> 1);
            else
                wait_len = 17'(period_reg);
            if (tick_cnt >= wait_len) begin
                tick_cnt = '0;
                if (step_idx >= FIRST_BIT_STEP && step_idx <= LAST_BIT_STEP)
                    shift_reg = shift_reg | (8'(x.rx_line) << (step_idx - FIRST_BIT_STEP));
                if (step_idx >= LAST_STEP) begin
                    last_rx = shift_reg;
                    if (held_count < DEPTH) begin
                        byte_mem[held_count[4:0]] = shift_reg;
                        held_count = held_count + 6'd1;
                        stored = 1'b1;
                    end else begin
                        ovf_flag = 1'b1;
                    end
                    rx_phase = PH_GAP;
                    gap_cnt  = '0;
                    step_idx = '0;
                end else begin
                    step_idx = step_idx + 4'd1;
                end
            end
        end else if (rx_phase == PH_GAP) begin
            if (!x.rx_line) begin
                start_byte();
            end else begin
                if (gap_cnt < GAP_MAX)
                    gap_cnt = gap_cnt + 16'd1;
                if (gap_cnt >= gap_reg) begin
                    ended    = 1'b1;
                    rx_phase = PH_IDLE;
                    gap_cnt  = '0;
                end
            end
        end else if (!x.rx_line) begin
            start_byte();
        end
        r.byte_valid = stored;
        r.rx_byte    = last_rx;
        r.byte_count = held_count;
        r.receiving  = (rx_phase != PH_IDLE);
        r.frame_end  = ended;
        r.overflow   = ovf_flag;
        r.read_data  = (x.read_index < held_count) ? byte_mem[x.read_index] : 8'h00;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s expected %0h got %0h", name, want, got);
            err_count++;
        end
    endfunction

    // result checker
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (rx_out_queue.size() == 0) begin
                $error("result transfer with nothing expected");
                err_count++;
            end else begin
                want_out = rx_out_queue.pop_front();
                check_field("byte_valid", 8'(want_out.byte_valid), 8'(out_item.byte_valid));
                check_field("rx_byte", want_out.rx_byte, out_item.rx_byte);
                check_field("byte_count", 8'(want_out.byte_count), 8'(out_item.byte_count));
                check_field("receiving", 8'(want_out.receiving), 8'(out_item.receiving));
                check_field("frame_end", 8'(want_out.frame_end), 8'(out_item.frame_end));
                check_field("overflow", 8'(want_out.overflow), 8'(out_item.overflow));
                check_field("read_data", want_out.read_data, out_item.read_data);
                n_bytes  += want_out.byte_valid;
                n_frames += want_out.frame_end;
                n_ovf    += want_out.overflow;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, rx_out_queue.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output side: random stalls, long hold-off on request
    initial begin
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
                out_ready <= 1'b1;
            end else begin
                out_ready <= !(idling && $urandom_range(99) < 33);
            end
        end
    end

    task automatic put_tick(input logic cmd, input logic line, input logic [4:0] ridx);
        t_rx_in x;
        x.command    = cmd;
        x.rx_line    = line;
        x.read_index = ridx;
        while (idling && $urandom_range(99) < 33) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= x;
        do @(posedge clk); while (!in_ready);
        rx_out_queue.push_back(rx_tick_predict(x));
        n_ticks++;
        n_clears += cmd;
        @(negedge clk);
    endtask

    task automatic put_noise(input int count, input int clear_pct);
        repeat (count)
            put_tick(($urandom_range(99) < clear_pct) ? CMD_CLEAR : CMD_SAMPLE,
                     1'($urandom_range(1)), 5'($urandom_range(31)));
    endtask

    // start bit, 8 data bits lsb first, stop bit, then gap_len idle ticks
    task automatic put_frame(input logic [7:0] value, input int cut, input int gap_len,
                             input int clear_pct);
        int   p;
        logic lvl;
        p = int'(period_reg);
        for (int t = 0; t <= 10 * p && t < cut; t++) begin
            if (t < p)
                lvl = 1'b0;
            else if (t < 9 * p)
                lvl = value[t / p - 1];
            else
                lvl = 1'b1;
            if ($urandom_range(99) < clear_pct)
                put_tick(CMD_CLEAR, 1'($urandom_range(1)), 5'($urandom_range(31)));
            put_tick(CMD_SAMPLE, lvl, 5'($urandom_range(31)));
        end
        repeat (gap_len) put_tick(CMD_SAMPLE, 1'b1, 5'($urandom_range(31)));
    endtask

    // zero-length waits: start, one wait tick, eight data ticks, two stop ticks
    task automatic put_fast_byte(input logic [7:0] value, input int gap_len);
        put_tick(CMD_SAMPLE, 1'b0, 5'($urandom_range(31)));
        put_tick(CMD_SAMPLE, 1'b0, 5'($urandom_range(31)));
        for (int b = 0; b < 8; b++) put_tick(CMD_SAMPLE, value[b], 5'($urandom_range(31)));
        repeat (2 + gap_len) put_tick(CMD_SAMPLE, 1'b1, 5'($urandom_range(31)));
    endtask

    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (rx_out_queue.size() != 0) @(negedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BIT_PERIOD)
            period_reg = value;
        else
            gap_reg = value;
        @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] period, input logic [15:0] gap);
        wait_results_done();
        write_reg(CFG_BIT_PERIOD, period);
        write_reg(CFG_GAP_TICKS, gap);
    endtask

    task automatic test_reset_state();
        put_tick(CMD_SAMPLE, 1'b1, 5'd0);
        put_tick(CMD_SAMPLE, 1'b1, 5'd31);
        put_tick(CMD_CLEAR, 1'b0, 5'd31);
        put_tick(CMD_SAMPLE, 1'b1, 5'd0);
        put_tick(CMD_SAMPLE, 1'b0, 5'd10);
        put_noise(10, 0);
    endtask

    task automatic test_byte_extremes();
        set_config(16'd4, 16'd1);
        put_frame(8'h00, FULL_FRAME, 0, 0);
        put_frame(8'hff, FULL_FRAME, 1, 0);
        put_frame(8'ha5, FULL_FRAME, 2, 0);
        set_config(16'd5, 16'd2);
        put_frame(8'h5a, FULL_FRAME, 3, 0);
        put_frame(8'h3c, FULL_FRAME, 3, 10);
    endtask

    task automatic test_short_waits();
        set_config(16'd1, 16'd0);
        put_tick(CMD_SAMPLE, 1'b0, 5'd0);
        put_noise(30, 0);
        set_config(16'd0, 16'd0);
        put_tick(CMD_SAMPLE, 1'b0, 5'd1);
        put_noise(30, 0);
        set_config(16'd2, 16'd1);
        put_tick(CMD_SAMPLE, 1'b0, 5'd2);
        put_noise(30, 0);
    endtask

    task automatic test_buffer_overflow();
        set_config(16'd0, 16'd8);
        repeat (DEPTH + 2) put_fast_byte(8'($urandom_range(255)), int'($urandom_range(2)));
        for (int i = 0; i < DEPTH; i++) put_tick(CMD_SAMPLE, 1'b1, 5'(i));
        put_tick(CMD_CLEAR, 1'b1, 5'd0);
        put_tick(CMD_SAMPLE, 1'b1, 5'd0);
        put_fast_byte(8'($urandom_range(255)), 12);
    endtask

    task automatic test_output_stall();
        set_config(16'd4, 16'd20);
        hold_req = 1'b1;
        put_frame(8'($urandom_range(255)), FULL_FRAME, 25, 0);
        wait_results_done();
    endtask

    task automatic test_register_limits();
        idling = 1'b0;
        set_config(16'd4, GAP_MAX);
        put_frame(8'($urandom_range(255)), FULL_FRAME, 40, 0);
        put_noise(5, 0);
        set_config(GAP_MAX, 16'd3);
        put_tick(CMD_SAMPLE, 1'b0, 5'd0);
        put_noise(60, 0);
        // pending wait is already past the new length
        set_config(16'd4, 16'd3);
        put_noise(30, 2);
        idling = 1'b1;
    endtask

    task automatic test_random_traffic();
        int target;
        int kind;
        for (int s = 0; s < 5; s++) begin
            if (s == 0)
                set_config(16'd4, 16'd1);
            else if (s == 4)
                set_config(16'd16, 16'($urandom_range(1, 24)));
            else
                set_config(16'($urandom_range(4, 9)), 16'($urandom_range(1, 24)));
            target = n_ticks + 40;
            while (n_ticks < target) begin
                kind = $urandom_range(99);
                if (kind < 75) begin
                    put_frame(8'($urandom_range(255)), FULL_FRAME,
                              int'($urandom_range(0, int'(gap_reg) + 4)), 2);
                end else if (kind < 90) begin
                    put_noise(int'($urandom_range(5, 30)), 3);
                end else begin
                    put_frame(8'($urandom_range(255)),
                              int'($urandom_range(1, 10 * int'(period_reg))), 0, 0);
                    put_noise(int'($urandom_range(1, 10)), 3);
                end
            end
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_BIT_PERIOD;
        cfg_data    = '0;
        idling      = 1'b1;
        hold_req    = 1'b0;
        err_count   = 0;
        cycle_count = 0;
        n_ticks     = 0;
        n_clears    = 0;
        n_bytes     = 0;
        n_frames    = 0;
        n_ovf       = 0;
        rx_phase    = PH_IDLE;
        tick_cnt    = '0;
        step_idx    = '0;
        shift_reg   = '0;
        gap_cnt     = '0;
        held_count  = '0;
        ovf_flag    = 1'b0;
        last_rx     = '0;
        period_reg  = BIT_PERIOD_RST;
        gap_reg     = GAP_TICKS_RST;
        foreach (byte_mem[i]) byte_mem[i] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_byte_extremes();
        test_short_waits();
        test_buffer_overflow();
        test_output_stall();
        test_register_limits();
        test_random_traffic();

        wait_results_done();
        repeat (4) @(posedge clk);
        $display("covered %0d line ticks with %0d clears: %0d bytes stored, %0d frame ends",
                 n_ticks, n_clears, n_bytes, n_frames);
        $display("%0d results carried the overflow flag", n_ovf);
        if (err_count == 0 && rx_out_queue.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
